FILE: rtl/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg: shared types and constants of the dda line rasterizer
// field widths, fixed-point format and sequencer state codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlr_pkg;

  localparam int unsigned COORD_W       = 20;  // unsigned Q12.8
  localparam int unsigned COLOR_W       = 24;
  localparam int unsigned PIX_W         = 12;
  localparam int unsigned FRAC_BITS     = 8;
  localparam int unsigned MAX_STEPS_DEF = 64;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_DIVX  = 5'b00100,
    ST_DIVY  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/dlr_if.sv
// ----------------------------------------------------------------------------
// dlr channel interfaces
// line item channel in, pixel item channel out, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dlr_line_if;
  logic                        valid;
  logic                        ready;
  logic [dlr_pkg::COORD_W-1:0] start_x;
  logic [dlr_pkg::COORD_W-1:0] start_y;
  logic [dlr_pkg::COORD_W-1:0] end_x;
  logic [dlr_pkg::COORD_W-1:0] end_y;
  logic [dlr_pkg::COLOR_W-1:0] pen_color;

  modport source (output valid, start_x, start_y, end_x, end_y, pen_color, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, pen_color, output ready);
endinterface

interface dlr_pix_if;
  logic                        valid;
  logic                        ready;
  logic [dlr_pkg::PIX_W-1:0]   pix_x;
  logic [dlr_pkg::PIX_W-1:0]   pix_y;
  logic [dlr_pkg::COLOR_W-1:0] pix_color;
  logic                        last_pixel;

  modport source (output valid, pix_x, pix_y, pix_color, last_pixel, input ready);
  modport sink   (input valid, pix_x, pix_y, pix_color, last_pixel, output ready);
endinterface

`default_nettype wire

FILE: rtl/dlr_divider.sv
// ----------------------------------------------------------------------------
// dlr_divider: serial restoring divider
// one quotient bit per cycle, unsigned magnitude by small unsigned count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlr_divider #(
  parameter int unsigned DEN_W = 7
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [dlr_pkg::COORD_W-1:0] num_i,
  input  wire logic [DEN_W-1:0]            den_i,
  output logic                             done_o,
  output logic [dlr_pkg::COORD_W-1:0]      quo_o
);

  localparam int unsigned NUM_W = dlr_pkg::COORD_W;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic                busy_q, busy_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [NUM_W-1:0]    quo_q, quo_d;
  logic [DEN_W-1:0]    rem_q, rem_d;
  logic [DEN_W-1:0]    den_q, den_d;
  logic [DEN_W:0]      trial;
  logic                fits;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        quo_d = {quo_q[NUM_W-2:0], fits};
        rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule

`default_nettype wire

FILE: rtl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer: fixed-point dda line walker
// divides the deltas by the step count on one serial divider, then walks
// ----------------------------------------------------------------------------
// order: after a line item is accepted come the setup state, the x divide and
//   the y divide on the one shared divider, then the first pixel load
// throughput: one pixel a cycle during the walk when the sink never stalls;
//   a line with zero steps goes from setup straight back to idle, no pixel
// reset: rst_ni asynchronous active low, clears the sequencer and the
//   output valid; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module dda_line_rasterizer #(
  parameter int unsigned MAX_STEPS = dlr_pkg::MAX_STEPS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dlr_line_if.sink   line_i,
  dlr_pix_if.source  pix_o
);

  localparam int unsigned CW     = dlr_pkg::COORD_W;
  localparam int unsigned FB     = dlr_pkg::FRAC_BITS;
  localparam int unsigned PW     = dlr_pkg::PIX_W;
  localparam int unsigned STEP_W = $clog2(MAX_STEPS + 1);

  dlr_pkg::state_e state_q, state_d;

  // captured line item
  logic [CW-1:0]               sx_q, sy_q, ex_q, ey_q;
  logic [dlr_pkg::COLOR_W-1:0] color_q;

  // setup results
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [CW-1:0]     ady_q;
  logic              negx_q, negy_q;

  // walk state
  logic [CW-1:0]     px_q, px_d, py_q, py_d;
  logic [CW-1:0]     xinc_q, yinc_q;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  // output register, holds its own color so a new line item can be
  // taken while the last pixel item still waits
  logic                        out_valid_q, out_valid_d;
  logic [PW-1:0]               out_x_q, out_y_q;
  logic [dlr_pkg::COLOR_W-1:0] out_color_q;
  logic                        out_last_q;

  // setup arithmetic: deltas, magnitudes, saturated step count
  logic [CW:0]       dx, dy;
  logic [CW-1:0]     adx, ady, big;
  logic [CW-FB-1:0]  steps_raw;
  logic [STEP_W-1:0] steps_sat;

  // shared divider
  logic              div_start, div_done;
  logic [CW-1:0]     div_num, div_quo;
  logic [CW-1:0]     quo_signed;

  logic accept, out_free, load_pix, is_last;

  assign accept   = line_i.valid && line_i.ready;
  assign out_free = !out_valid_q || pix_o.ready;
  assign is_last  = (STEP_W'(cnt_q + 1'b1) == steps_q);
  assign load_pix = (state_q == dlr_pkg::ST_EMIT) && out_free;

  assign line_i.ready = (state_q == dlr_pkg::ST_IDLE);

  assign dx  = {1'b0, ex_q} - {1'b0, sx_q};
  assign dy  = {1'b0, ey_q} - {1'b0, sy_q};
  assign adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign big = (ady > adx) ? ady : adx;
  assign steps_raw = big[CW-1:FB];
  // long lines clamp to the step limit
  assign steps_sat = (steps_raw > (CW-FB)'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
                                                       : steps_raw[STEP_W-1:0];

  // x divide starts from setup, y divide starts as x finishes
  assign div_start = ((state_q == dlr_pkg::ST_SETUP) && (steps_sat != '0)) ||
                     ((state_q == dlr_pkg::ST_DIVX) && div_done);
  assign div_num   = (state_q == dlr_pkg::ST_SETUP) ? adx : ady_q;

  // sign goes back on after the magnitude divide (truncation toward zero)
  assign quo_signed = (((state_q == dlr_pkg::ST_DIVX) && negx_q) ||
                       ((state_q == dlr_pkg::ST_DIVY) && negy_q)) ? CW'(-div_quo) : div_quo;

  dlr_divider #(
    .DEN_W (STEP_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ((state_q == dlr_pkg::ST_SETUP) ? steps_sat : steps_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      dlr_pkg::ST_IDLE:  if (accept) state_d = dlr_pkg::ST_SETUP;
      dlr_pkg::ST_SETUP: state_d = (steps_sat == '0) ? dlr_pkg::ST_IDLE : dlr_pkg::ST_DIVX;
      dlr_pkg::ST_DIVX:  if (div_done) state_d = dlr_pkg::ST_DIVY;
      dlr_pkg::ST_DIVY:  if (div_done) state_d = dlr_pkg::ST_EMIT;
      dlr_pkg::ST_EMIT:  if (load_pix && is_last) state_d = dlr_pkg::ST_IDLE;
      default:           state_d = dlr_pkg::ST_IDLE;
    endcase
  end

  // walk: positions accumulate modulo 2^20, they stay between start and end
  always_comb begin
    steps_d = steps_q;
    px_d    = px_q;
    py_d    = py_q;
    cnt_d   = cnt_q;
    if (state_q == dlr_pkg::ST_SETUP) begin
      steps_d = steps_sat;
      px_d    = sx_q;
      py_d    = sy_q;
      cnt_d   = '0;
    end else if (load_pix) begin
      px_d  = px_q + xinc_q;
      py_d  = py_q + yinc_q;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_pix) begin
      out_valid_d = 1'b1;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q    <= line_i.start_x;
      sy_q    <= line_i.start_y;
      ex_q    <= line_i.end_x;
      ey_q    <= line_i.end_y;
      color_q <= line_i.pen_color;
    end
    if (state_q == dlr_pkg::ST_SETUP) begin
      ady_q  <= ady;
      negx_q <= dx[CW];
      negy_q <= dy[CW];
    end
    if ((state_q == dlr_pkg::ST_DIVX) && div_done) xinc_q <= quo_signed;
    if ((state_q == dlr_pkg::ST_DIVY) && div_done) yinc_q <= quo_signed;
    steps_q <= steps_d;
    px_q    <= px_d;
    py_q    <= py_d;
    cnt_q   <= cnt_d;
    if (load_pix) begin
      out_x_q     <= px_q[CW-1:FB];
      out_y_q     <= py_q[CW-1:FB];
      out_color_q <= color_q;
      out_last_q  <= is_last;
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.pix_x      = out_x_q;
  assign pix_o.pix_y      = out_y_q;
  assign pix_o.pix_color  = out_color_q;
  assign pix_o.last_pixel = out_last_q;

  // divider finishes only while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == dlr_pkg::ST_DIVX || state_q == dlr_pkg::ST_DIVY))
    else $error("divider done outside a divide state");

  // the walk never runs past the step count
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dlr_pkg::ST_EMIT) |-> (cnt_q < steps_q && steps_q != '0))
    else $error("pixel counter out of range");

  // the last pixel ends the line
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_pix && is_last) |=> (state_q == dlr_pkg::ST_IDLE && out_valid_q && out_last_q))
    else $error("last pixel did not end the line");

  // no new line item is taken while pixels of a line are still to be loaded
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dlr_pkg::ST_EMIT) |-> !line_i.ready)
    else $error("line item accepted during walk");

endmodule

`default_nettype wire
